/* design/dhd_pkg.sv */
// shared types and constants for the door hold event debouncer
`timescale 1ns / 1ps

package dhd_pkg;

    localparam int HW_SLOTS      = 4;
    localparam int MAX_SLOTS     = 4;
    localparam int EFF_SLOTS     = (MAX_SLOTS < HW_SLOTS) ? MAX_SLOTS : HW_SLOTS;
    localparam int SLOT_IDX_BITS = 2;
    localparam int COUNT_BITS    = 3;
    localparam int HOLD_BITS     = 16;
    localparam int NEED_BITS     = 26;
    localparam int NOW_BITS      = 48;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 16;

    localparam logic [HOLD_BITS-1:0] DEBOUNCE_RESET = 16'd10000;
    localparam logic [NEED_BITS-1:0] US_PER_MS      = 26'd1000;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_SLOT_COUNT = 3'd0,
        REG_WATCH_OPEN = 3'd1,
        REG_HOLD_0     = 3'd2,
        REG_HOLD_1     = 3'd3,
        REG_HOLD_2     = 3'd4,
        REG_HOLD_3     = 3'd5,
        REG_DEBOUNCE   = 3'd6
    } cfg_reg_t;

    typedef struct packed {
        logic [COUNT_BITS-1:0]                  slot_count;
        logic [HW_SLOTS-1:0]                    watch_open;
        logic [HW_SLOTS-1:0][HOLD_BITS-1:0]     hold_ms;
        logic [HW_SLOTS-1:0][NEED_BITS-1:0]     need_us;
        logic [HOLD_BITS-1:0]                   debounce_us;
    } cfg_t;

    typedef struct packed {
        logic [SLOT_IDX_BITS-1:0] slot_index;
        logic                     door_open;
        logic [HOLD_BITS-1:0]     hold_ms;
        logic                     last_in_run;
    } event_t;

endpackage

/* design/dhd_cfg.sv */
// configuration registers with precomputed hold thresholds in microseconds
`timescale 1ns / 1ps

module dhd_cfg
    import dhd_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     wr_en,
    input  logic [CFG_IDX_BITS-1:0]  wr_index,
    input  logic [CFG_DATA_BITS-1:0] wr_data,
    output cfg_t                     cfg
);

    // all fields zero except debounce_us, which sits in the low bits
    localparam cfg_t CFG_RESET = cfg_t'({{($bits(cfg_t) - HOLD_BITS){1'b0}}, DEBOUNCE_RESET});

    cfg_t                 cfg_reg;
    logic [NEED_BITS-1:0] need_next;

    // ms to us, 16 x 10 bit product
    assign need_next = NEED_BITS'(wr_data) * US_PER_MS;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_SLOT_COUNT: cfg_reg.slot_count <= wr_data[COUNT_BITS-1:0];
                REG_WATCH_OPEN: cfg_reg.watch_open <= wr_data[HW_SLOTS-1:0];
                REG_HOLD_0:
                begin
                    cfg_reg.hold_ms[0] <= wr_data;
                    cfg_reg.need_us[0] <= need_next;
                end
                REG_HOLD_1:
                begin
                    cfg_reg.hold_ms[1] <= wr_data;
                    cfg_reg.need_us[1] <= need_next;
                end
                REG_HOLD_2:
                begin
                    cfg_reg.hold_ms[2] <= wr_data;
                    cfg_reg.need_us[2] <= need_next;
                end
                REG_HOLD_3:
                begin
                    cfg_reg.hold_ms[3] <= wr_data;
                    cfg_reg.need_us[3] <= need_next;
                end
                REG_DEBOUNCE:   cfg_reg.debounce_us <= wr_data;
                default:        ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

/* design/dhd_tracker.sv */
// debounced door state tracking and hold-time slot evaluation
`timescale 1ns / 1ps

module dhd_tracker
    import dhd_pkg::*;
#(
    parameter int TIME_BITS = 48
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 go,
    input  logic                 pin_high,
    input  logic [TIME_BITS-1:0] now,
    input  cfg_t                 cfg,
    output logic [HW_SLOTS-1:0]  fire
);

    logic                 primed_reg;
    logic                 tracked_open_reg;
    logic [TIME_BITS-1:0] change_time_reg;
    logic [TIME_BITS-1:0] accept_time_reg;
    logic [HW_SLOTS-1:0]  fired_flags_reg;

    logic                 is_open;
    logic [TIME_BITS-1:0] since;
    logic [TIME_BITS-1:0] held;
    logic                 accepted;
    logic [HW_SLOTS-1:0]  flags_base;
    logic [HW_SLOTS-1:0]  enabled;

    assign is_open  = !pin_high;
    assign since    = now - accept_time_reg;
    assign accepted = primed_reg && (is_open != tracked_open_reg)
                      && (since > TIME_BITS'(cfg.debounce_us));
    // an accepted change restarts the hold timer at this very sample
    assign held       = accepted ? '0 : (now - change_time_reg);
    assign flags_base = accepted ? '0 : fired_flags_reg;

    always_comb
    begin
        for (int i = 0; i < HW_SLOTS; i++)
        begin
            enabled[i] = (int'(cfg.slot_count) > i) && (i < EFF_SLOTS);
            fire[i]    = primed_reg && enabled[i]
                         && (cfg.watch_open[i] == is_open)
                         && (held >= TIME_BITS'(cfg.need_us[i]))
                         && !flags_base[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            primed_reg       <= 1'b0;
            tracked_open_reg <= 1'b0;
            change_time_reg  <= '0;
            accept_time_reg  <= '0;
            fired_flags_reg  <= '1;
        end
        else if (go)
        begin
            if (!primed_reg)
            begin
                primed_reg       <= 1'b1;
                tracked_open_reg <= is_open;
                change_time_reg  <= now;
            end
            else
            begin
                if (accepted)
                begin
                    tracked_open_reg <= is_open;
                    change_time_reg  <= now;
                    accept_time_reg  <= now;
                end
                fired_flags_reg <= flags_base | fire;
            end
        end
    end

endmodule

/* design/dhd_emitter.sv */
// drains the fired-slot mask one event per cycle into the output register, stalling while out_ready is low
`timescale 1ns / 1ps

module dhd_emitter
    import dhd_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  logic [HW_SLOTS-1:0] fire,
    input  cfg_t                cfg,
    input  logic                out_ready,
    output logic                busy,
    output logic                out_valid,
    output event_t              out_event
);

    logic [HW_SLOTS-1:0]      pend_reg;
    logic [HW_SLOTS-1:0]      pend_next;
    logic                     out_valid_reg;
    event_t                   out_event_reg;
    logic [SLOT_IDX_BITS-1:0] sel;
    logic [HW_SLOTS-1:0]      sel_mask;
    logic                     take;
    event_t                   ev_next;

    // lowest pending slot goes first
    always_comb
    begin
        sel = '0;
        for (int i = HW_SLOTS - 1; i >= 0; i--)
        begin
            if (pend_reg[i])
            begin
                sel = SLOT_IDX_BITS'(i);
            end
        end
        sel_mask = HW_SLOTS'(1) << sel;
    end

    assign take = (pend_reg != '0) && (!out_valid_reg || out_ready);

    always_comb
    begin
        ev_next.slot_index  = sel;
        ev_next.door_open   = cfg.watch_open[sel];
        ev_next.hold_ms     = cfg.hold_ms[sel];
        ev_next.last_in_run = ((pend_reg & ~sel_mask) == '0);
        pend_next           = pend_reg;
        if (take)
        begin
            pend_next = pend_reg & ~sel_mask;
        end
        if (load)
        begin
            pend_next = fire;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pend_reg <= pend_next;
            if (take)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            out_event_reg <= ev_next;
        end
    end

    assign busy      = (pend_reg != '0);
    assign out_valid = out_valid_reg;
    assign out_event = out_event_reg;

endmodule

/* design/door_hold_event_debouncer.sv */
// path: a sample passes the input register, then the emitter's pending mask, then its output event register
// throughput: one sample per cycle while no slot fires; a sample that fires
// slots holds the evaluation register until every fired slot has emitted its event
// (the emitter drains one event per cycle, stalling while out_ready is low)
// reset: asynchronous active low; state unprimed, all fired flags set,
// debounce_us 10000, other registers zero except the unreset sample and event data
`timescale 1ns / 1ps

module door_hold_event_debouncer
    import dhd_pkg::*;
#(
    parameter int TIME_BITS = 48
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic                     pin_high,
    input  logic [NOW_BITS-1:0]      now_us,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [SLOT_IDX_BITS-1:0] slot_index,
    output logic                     door_open,
    output logic [HOLD_BITS-1:0]     hold_ms,
    output logic                     last_in_run,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data
);

    logic                 in_valid_reg;
    logic                 pin_reg;
    logic [TIME_BITS-1:0] now_reg;
    logic                 go;
    logic                 busy;
    logic [HW_SLOTS-1:0]  fire;
    cfg_t                 cfg;
    event_t               out_event;

    assign cfg_ready = 1'b1;
    assign go        = in_valid_reg && !busy;
    assign in_ready  = !in_valid_reg || go;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            pin_reg <= pin_high;
            now_reg <= TIME_BITS'({{(64 - NOW_BITS){1'b0}}, now_us});
        end
    end

    dhd_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    dhd_tracker #(
        .TIME_BITS (TIME_BITS)
    ) u_tracker (
        .clk      (clk),
        .rst_n    (rst_n),
        .go       (go),
        .pin_high (pin_reg),
        .now      (now_reg),
        .cfg      (cfg),
        .fire     (fire)
    );

    dhd_emitter u_emitter (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (go),
        .fire      (fire),
        .cfg       (cfg),
        .out_ready (out_ready),
        .busy      (busy),
        .out_valid (out_valid),
        .out_event (out_event)
    );

    assign slot_index  = out_event.slot_index;
    assign door_open   = out_event.door_open;
    assign hold_ms     = out_event.hold_ms;
    assign last_in_run = out_event.last_in_run;

endmodule

/* verif/tb_top.sv */
// self-checking testbench for the door hold event debouncer
`timescale 1ns / 1ps

module tb_top;
    import dhd_pkg::*;

    localparam int CYCLE_LIMIT = 100000;
    localparam int SETTLE_CYCLES = 4;
    localparam int PHASES = 8;
    localparam int PHASE_SAMPLES = 25;

    typedef enum logic {ROW_WRITE, ROW_SAMPLE} row_kind_t;

    typedef struct {
        row_kind_t             kind;
        cfg_reg_t              reg_index;
        logic [CFG_DATA_BITS-1:0] reg_value;
        logic                  pin;
        logic [NOW_BITS-1:0]   stamp;
        bit                    typed;
        logic [HW_SLOTS-1:0]   fired;
    } step_row_t;

    logic                     clk;
    logic                     rst_n;
    logic                     in_valid;
    logic                     in_ready;
    logic                     pin_high;
    logic [NOW_BITS-1:0]      now_us;
    logic                     out_valid;
    logic                     out_ready;
    logic [SLOT_IDX_BITS-1:0] slot_index;
    logic                     door_open;
    logic [HOLD_BITS-1:0]     hold_ms;
    logic                     last_in_run;
    logic                     cfg_valid;
    logic                     cfg_ready;
    logic [CFG_IDX_BITS-1:0]  cfg_index;
    logic [CFG_DATA_BITS-1:0] cfg_data;

    // register shadow
    logic [COUNT_BITS-1:0]    shadow_count;
    logic [HW_SLOTS-1:0]      shadow_watch;
    logic [HOLD_BITS-1:0]     shadow_hold [HW_SLOTS];
    logic [HOLD_BITS-1:0]     shadow_debounce;

    // tracked contact state
    logic                     trk_primed;
    logic                     trk_open;
    logic [NOW_BITS-1:0]      trk_change_us;
    logic [NOW_BITS-1:0]      trk_accept_us;
    logic [HW_SLOTS-1:0]      trk_fired;

    event_t                   due_events [$];
    int                       mismatches;
    bit                       tx_idle;
    bit                       rx_idle;
    bit                       cfg_streaming;

    door_hold_event_debouncer dut (.*);

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic step_row_t write_row(cfg_reg_t idx, logic [CFG_DATA_BITS-1:0] value);
        step_row_t row;
        row = '{ROW_WRITE, idx, value, 1'b0, '0, 1'b0, '0};
        return row;
    endfunction

    function automatic step_row_t sample_row(logic pin, logic [NOW_BITS-1:0] stamp);
        step_row_t row;
        row = '{ROW_SAMPLE, REG_SLOT_COUNT, '0, pin, stamp, 1'b0, '0};
        return row;
    endfunction

    function automatic step_row_t checked_row(logic pin, logic [NOW_BITS-1:0] stamp,
                                              logic [HW_SLOTS-1:0] fired);
        step_row_t row;
        row = '{ROW_SAMPLE, REG_SLOT_COUNT, '0, pin, stamp, 1'b1, fired};
        return row;
    endfunction

    function automatic void apply_setting(cfg_reg_t idx, logic [CFG_DATA_BITS-1:0] value);
        case (idx)
            REG_SLOT_COUNT: shadow_count = value[COUNT_BITS-1:0];
            REG_WATCH_OPEN: shadow_watch = value[HW_SLOTS-1:0];
            REG_HOLD_0:     shadow_hold[0] = value;
            REG_HOLD_1:     shadow_hold[1] = value;
            REG_HOLD_2:     shadow_hold[2] = value;
            REG_HOLD_3:     shadow_hold[3] = value;
            REG_DEBOUNCE:   shadow_debounce = value;
            default:        ;
        endcase
    endfunction

    // debounce the sample and return the mask of slots whose hold event fires
    function automatic logic [HW_SLOTS-1:0] advance_door_state(logic pin,
                                                               logic [NOW_BITS-1:0] stamp);
        logic                is_open;
        logic [NOW_BITS-1:0] since;
        logic [NOW_BITS-1:0] held;
        logic [NOW_BITS-1:0] need;
        logic [HW_SLOTS-1:0] fired;
        int                  active;
        is_open = ~pin;
        fired = '0;
        if (!trk_primed)
        begin
            trk_primed = 1'b1;
            trk_open = is_open;
            trk_change_us = stamp;
            return fired;
        end
        since = stamp - trk_accept_us;
        if (is_open != trk_open && since > NOW_BITS'(shadow_debounce))
        begin
            trk_accept_us = stamp;
            trk_change_us = stamp;
            trk_open = is_open;
            trk_fired = '0;
        end
        active = (shadow_count > EFF_SLOTS) ? EFF_SLOTS : int'(shadow_count);
        held = stamp - trk_change_us;
        for (int i = 0; i < active; i++)
        begin
            need = NOW_BITS'(shadow_hold[i]) * NOW_BITS'(US_PER_MS);
            if (shadow_watch[i] == is_open && held >= need && !trk_fired[i])
            begin
                trk_fired[i] = 1'b1;
                fired[i] = 1'b1;
            end
        end
        return fired;
    endfunction

    function automatic void queue_events(logic [HW_SLOTS-1:0] fired);
        event_t ev;
        for (int i = 0; i < HW_SLOTS; i++)
        begin
            if (fired[i])
            begin
                ev.slot_index = SLOT_IDX_BITS'(i);
                ev.door_open = shadow_watch[i];
                ev.hold_ms = shadow_hold[i];
                ev.last_in_run = (fired >> (i + 1)) == '0;
                due_events.push_back(ev);
            end
        end
    endfunction

    task automatic log_mismatch(string what);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch: %s", what);
    endtask

    task automatic send_sample(logic pin, logic [NOW_BITS-1:0] stamp, bit drain, bit typed,
                               logic [HW_SLOTS-1:0] typed_fired);
        int                  gap;
        logic [HW_SLOTS-1:0] fired;
        gap = tx_idle ? $urandom_range(0, 5) : 0;
        if (drain || gap != 0)
            in_valid <= 1'b0;
        // hold off until the block has delivered everything owed so far
        if (drain)
            do @(posedge clk); while (due_events.size() != 0);
        repeat (gap) @(posedge clk);
        in_valid <= 1'b1;
        pin_high <= pin;
        now_us <= stamp;
        do @(posedge clk); while (!in_ready);
        fired = advance_door_state(pin, stamp);
        queue_events(typed ? typed_fired : fired);
    endtask

    task automatic cfg_write(cfg_reg_t idx, logic [CFG_DATA_BITS-1:0] value, bit last);
        if (!cfg_streaming)
        begin
            in_valid <= 1'b0;
            while (due_events.size() != 0) @(posedge clk);
            repeat (SETTLE_CYCLES) @(posedge clk);
        end
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(posedge clk); while (!cfg_ready);
        apply_setting(idx, value);
        cfg_streaming = !last;
        if (last)
            cfg_valid <= 1'b0;
    endtask

    initial
    begin : event_sink
        event_t got;
        event_t want;
        int     stall;
        stall = 0;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                got = {slot_index, door_open, hold_ms, last_in_run};
                if (due_events.size() == 0)
                    log_mismatch($sformatf("unexpected event slot %0d open %0b hold %0d last %0b",
                                           got.slot_index, got.door_open, got.hold_ms,
                                           got.last_in_run));
                else
                begin
                    want = due_events.pop_front();
                    if (got.slot_index !== want.slot_index || got.door_open !== want.door_open ||
                        got.hold_ms !== want.hold_ms || got.last_in_run !== want.last_in_run)
                        log_mismatch($sformatf({"got slot %0d open %0b hold %0d last %0b, ",
                                                "expected slot %0d open %0b hold %0d last %0b"},
                                               got.slot_index, got.door_open, got.hold_ms,
                                               got.last_in_run, want.slot_index,
                                               want.door_open, want.hold_ms,
                                               want.last_in_run));
                end
                stall = rx_idle ? $urandom_range(0, 5) : 0;
                if (stall != 0)
                    out_ready <= 1'b0;
            end
            else if (!out_ready)
            begin
                if (stall <= 1)
                begin
                    out_ready <= 1'b1;
                    stall = 0;
                end
                else
                    stall--;
            end
        end
    end

    initial
    begin : stimulus
        step_row_t                steps [$];
        logic [NOW_BITS-1:0]      stamp_us;
        logic                     level;
        logic [CFG_DATA_BITS-1:0] val;
        bit                       drain;
        int                       pick;

        rst_n = 1'b0;
        in_valid = 1'b0;
        pin_high = 1'b0;
        now_us = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_SLOT_COUNT;
        cfg_data = '0;
        mismatches = 0;
        cfg_streaming = 1'b0;
        tx_idle = 1'b1;
        rx_idle = 1'b1;

        shadow_count = '0;
        shadow_watch = '0;
        foreach (shadow_hold[i])
            shadow_hold[i] = '0;
        shadow_debounce = DEBOUNCE_RESET;
        trk_primed = 1'b0;
        trk_open = 1'b0;
        trk_change_us = '0;
        trk_accept_us = '0;
        trk_fired = '1;

        // first sample only primes; nothing enabled out of reset
        steps.push_back(checked_row(1'b1, 48'd0, 4'b0000));
        steps.push_back(checked_row(1'b0, 48'd5000, 4'b0000));
        steps.push_back(write_row(REG_SLOT_COUNT, 16'd4));
        steps.push_back(write_row(REG_WATCH_OPEN, 16'b0101));
        steps.push_back(write_row(REG_HOLD_0, 16'd0));
        steps.push_back(write_row(REG_HOLD_1, 16'd0));
        steps.push_back(write_row(REG_HOLD_2, 16'd2));
        steps.push_back(write_row(REG_HOLD_3, 16'hFFFF));
        steps.push_back(write_row(REG_DEBOUNCE, 16'd10000));
        // exactly debounce_us is not enough, one more microsecond is
        steps.push_back(checked_row(1'b0, 48'd10000, 4'b0000));
        steps.push_back(checked_row(1'b0, 48'd10001, 4'b0001));
        steps.push_back(sample_row(1'b0, 48'd12001));
        // rejected bounce still fires on the raw level
        steps.push_back(sample_row(1'b1, 48'd12002));
        steps.push_back(sample_row(1'b1, 48'd20002));
        steps.push_back(checked_row(1'b1, 48'd65555001, 4'b0000));
        steps.push_back(checked_row(1'b1, 48'd65555002, 4'b1000));
        // timestamp going backwards, then the top of the range
        steps.push_back(sample_row(1'b0, 48'd0));
        steps.push_back(checked_row(1'b0, 48'hFFFF_FFFF_FFFF, 4'b0100));
        steps.push_back(write_row(REG_DEBOUNCE, 16'd0));
        steps.push_back(checked_row(1'b1, 48'd0, 4'b0010));
        steps.push_back(sample_row(1'b1, 48'd1));
        // oversized slot count clamps to the hardware slots
        steps.push_back(write_row(REG_SLOT_COUNT, 16'd7));
        steps.push_back(write_row(REG_WATCH_OPEN, 16'hF));
        steps.push_back(write_row(REG_HOLD_2, 16'd0));
        steps.push_back(write_row(REG_HOLD_3, 16'd0));
        steps.push_back(checked_row(1'b0, 48'd2, 4'b1111));
        steps.push_back(sample_row(1'b0, 48'd3));
        steps.push_back(write_row(REG_SLOT_COUNT, 16'd0));
        steps.push_back(sample_row(1'b1, 48'd100));
        steps.push_back(write_row(REG_SLOT_COUNT, 16'd2));
        steps.push_back(write_row(REG_WATCH_OPEN, 16'd0));
        steps.push_back(checked_row(1'b1, 48'd101, 4'b0011));
        // newly enabled slots keep their cleared fired flags
        steps.push_back(write_row(REG_SLOT_COUNT, 16'd4));
        steps.push_back(checked_row(1'b1, 48'd102, 4'b1100));
        steps.push_back(write_row(REG_DEBOUNCE, 16'hFFFF));
        steps.push_back(sample_row(1'b0, 48'd65637));
        steps.push_back(checked_row(1'b1, 48'd131172, 4'b1111));

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (steps[r])
        begin
            if (steps[r].kind == ROW_WRITE)
                cfg_write(steps[r].reg_index, steps[r].reg_value,
                          r + 1 == steps.size() || steps[r + 1].kind != ROW_WRITE);
            else
                send_sample(steps[r].pin, steps[r].stamp, 1'b0, steps[r].typed,
                            steps[r].fired);
        end

        stamp_us = 48'd131172;
        level = 1'b1;
        for (int phase = 0; phase < PHASES; phase++)
        begin
            tx_idle = (phase % 3) != 1;
            rx_idle = (phase % 3) != 1 && phase != 6;
            for (int j = 0; j <= int'(REG_DEBOUNCE); j++)
            begin
                case (cfg_reg_t'(j))
                    REG_SLOT_COUNT:
                        val = (phase == 1 || $urandom_range(0, 3) == 0) ?
                              16'($urandom_range(0, 7)) : 16'(HW_SLOTS);
                    REG_WATCH_OPEN:
                        val = 16'($urandom_range(0, 15));
                    REG_DEBOUNCE:
                        val = (phase == 2) ? 16'd0 : (phase == 5) ? 16'hFFFF :
                              16'($urandom_range(0, 20000));
                    default:
                    begin
                        pick = $urandom_range(0, 9);
                        val = (pick == 0) ? 16'hFFFF : (pick == 1) ? 16'($urandom()) :
                              16'($urandom_range(0, 40));
                    end
                endcase
                cfg_write(cfg_reg_t'(j), val, cfg_reg_t'(j) == REG_DEBOUNCE);
            end
            for (int k = 0; k < PHASE_SAMPLES; k++)
            begin
                pick = $urandom_range(0, 19);
                if (pick == 0)
                begin
                    // timestamp jump anywhere, often backwards
                    stamp_us = NOW_BITS'({$urandom(), $urandom()});
                    level = 1'($urandom_range(0, 1));
                end
                else if (pick < 4)
                begin
                    // contact bounce
                    stamp_us = stamp_us + NOW_BITS'($urandom_range(0, 60));
                    level = ~level;
                end
                else
                begin
                    stamp_us = stamp_us + NOW_BITS'($urandom_range(1000, 15000));
                    if ($urandom_range(0, 3) == 0)
                        level = ~level;
                end
                drain = $urandom_range(0, 29) == 0 || (phase == 3 && k == 12);
                send_sample(level, stamp_us, drain, 1'b0, '0);
            end
        end

        in_valid <= 1'b0;
        while (due_events.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
